[rtl/bcd_pkg.sv]
`default_nettype none

package bcd_pkg;

  typedef enum logic [1:0] {
    FMT_BC1 = 2'd0,
    FMT_BC2 = 2'd1,
    FMT_BC3 = 2'd2,
    FMT_RSV = 2'd3
  } fmt_e;

  localparam int unsigned InW  = 184;
  localparam int unsigned OutW = 64;

  typedef logic [7:0] chan_t;
  typedef chan_t [2:0] rgb_t;

  typedef struct packed {
    logic [11:0] bx;
    logic [11:0] by;
    logic [2:0]  ncol;
    logic [2:0]  nrow;
  } geo_t;

  typedef struct packed {
    fmt_e        fmt;
    logic        three;
    rgb_t        c0;
    rgb_t        c1;
    logic [31:0] idx;
    logic [63:0] aw;
    geo_t        geo;
  } prep_t;

  typedef struct packed {
    fmt_e                 fmt;
    logic                 three;
    rgb_t                 c0;
    rgb_t                 c1;
    logic [2:0][9:0]      mix2;
    logic [2:0][9:0]      mix3;
    rgb_t                 half;
    logic                 awide;
    logic [5:0][10:0]     s7;
    logic [3:0][10:0]     s5;
    logic [31:0]          idx;
    logic [63:0]          aw;
    geo_t                 geo;
  } sum_t;

  typedef struct packed {
    fmt_e                  fmt;
    logic [3:0][3:0][7:0]  pal;
    logic [7:0][7:0]       atab;
    logic [31:0]           idx;
    logic [63:0]           aw;
    geo_t                  geo;
  } block_t;

  typedef struct packed {
    chan_t       alpha;
    chan_t       blue;
    chan_t       green;
    chan_t       red;
    logic [13:0] y;
    logic [13:0] x;
  } texel_t;

endpackage

`default_nettype wire

[rtl/bc1_bc2_bc3_block_decoder.sv]
// Channel   Dir  Payload (low bit first)                                    Marks
// s_axis    in   color_word 64, alpha_word 64, mip_w 15,                    -
//                mip_h 15, block_col 12, block_row 12 (pad to 184)
// m_axis    out  texel_x 14, texel_y 14, red 8, green 8, blue 8, alpha 8    tlast = last_texel
//                (pad to 64)
// cfg       in   block_format 2                                             write enable
//
// A block passes three register stages (unpack and bounds, weighted sums, divides and
// palette) and is then serialized at one texel per cycle while m_axis_tready is high.
// The serializer emits only the texels that lie inside the level (16 for a full block)
// and none for a block outside it; it takes the next block as it emits the last texel.
// Reset clears all valid bits and sets block_format to BC1.
// A low m_axis_tready holds a valid output register, the serializer and every full stage behind it.
`default_nettype none

module bc1_bc2_bc3_block_decoder #(
  parameter int unsigned MAX_DIM = 16384
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_wdata_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // color_word, alpha_word, mip_w, mip_h, block_col, block_row
  input  wire logic [bcd_pkg::InW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // texel_x, texel_y, red, green, blue, alpha
  output logic [bcd_pkg::OutW-1:0]         m_axis_tdata,
  output logic                             m_axis_tlast
);
  import bcd_pkg::*;

  fmt_e   fmt_q;
  logic   prep_valid, prep_ready, blk_valid, blk_ready;
  prep_t  prep;
  block_t blk;
  texel_t texel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_BC1;
    end else if (cfg_we_i) begin
      fmt_q <= fmt_e'(cfg_wdata_i);
    end
  end

  bcd_prep #(
    .MAX_DIM(MAX_DIM)
  ) u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .fmt_i         (fmt_q),
    .color_word_i  (s_axis_tdata[63:0]),
    .alpha_word_i  (s_axis_tdata[127:64]),
    .mip_w_i       (s_axis_tdata[142:128]),
    .mip_h_i       (s_axis_tdata[157:143]),
    .block_col_i   (s_axis_tdata[169:158]),
    .block_row_i   (s_axis_tdata[181:170]),
    .out_valid_o   (prep_valid),
    .out_ready_i   (prep_ready),
    .out_o         (prep)
  );

  bcd_interp u_interp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (prep_valid),
    .in_ready_o (prep_ready),
    .in_i       (prep),
    .out_valid_o(blk_valid),
    .out_ready_i(blk_ready),
    .out_o      (blk)
  );

  bcd_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (blk_valid),
    .in_ready_o (blk_ready),
    .in_i       (blk),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (texel),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {(OutW - $bits(texel_t))'(0), texel};

endmodule

`default_nettype wire

[rtl/bcd_prep.sv]
`default_nettype none

module bcd_prep #(
  parameter int unsigned MAX_DIM = 16384
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bcd_pkg::fmt_e  fmt_i,
  input  wire logic [63:0]    color_word_i,
  input  wire logic [63:0]    alpha_word_i,
  input  wire logic [14:0]    mip_w_i,
  input  wire logic [14:0]    mip_h_i,
  input  wire logic [11:0]    block_col_i,
  input  wire logic [11:0]    block_row_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bcd_pkg::prep_t      out_o
);
  import bcd_pkg::*;

  function automatic rgb_t expand565(input logic [15:0] v);
    rgb_t rgb;
    rgb[0] = {v[15:11], v[15:13]};
    rgb[1] = {v[10:5], v[10:9]};
    rgb[2] = {v[4:0], v[4:2]};
    return rgb;
  endfunction

  logic        valid_q;
  prep_t       data_q, data_d;
  logic        en;
  logic [16:0] lim_w, lim_h;
  logic [3:0]  col_ok, row_ok;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    lim_w = (17'(mip_w_i) > 17'(MAX_DIM)) ? 17'(MAX_DIM) : 17'(mip_w_i);
    lim_h = (17'(mip_h_i) > 17'(MAX_DIM)) ? 17'(MAX_DIM) : 17'(mip_h_i);
    for (int k = 0; k < 4; k++) begin
      col_ok[k] = 17'({block_col_i, 2'(k)}) < lim_w;
      row_ok[k] = 17'({block_row_i, 2'(k)}) < lim_h;
    end
    data_d.fmt      = fmt_i;
    data_d.three    = (fmt_i == FMT_BC1) && (color_word_i[15:0] <= color_word_i[31:16]);
    data_d.c0       = expand565(color_word_i[15:0]);
    data_d.c1       = expand565(color_word_i[31:16]);
    data_d.idx      = color_word_i[63:32];
    data_d.aw       = alpha_word_i;
    data_d.geo.bx   = block_col_i;
    data_d.geo.by   = block_row_i;
    data_d.geo.ncol = 3'(col_ok[0]) + 3'(col_ok[1]) + 3'(col_ok[2]) + 3'(col_ok[3]);
    data_d.geo.nrow = 3'(row_ok[0]) + 3'(row_ok[1]) + 3'(row_ok[2]) + 3'(row_ok[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

[rtl/bcd_interp.sv]
`default_nettype none

module bcd_interp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire bcd_pkg::prep_t  in_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output bcd_pkg::block_t      out_o
);
  import bcd_pkg::*;

  function automatic chan_t div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  function automatic chan_t div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1639;
    return p[20:13];
  endfunction

  function automatic chan_t div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  logic   sum_valid_q, blk_valid_q;
  sum_t   sum_q, sum_d;
  block_t blk_q, blk_d;
  logic   sum_en, blk_en;
  chan_t  a0, a1;

  assign blk_en     = !blk_valid_q || out_ready_i;
  assign sum_en     = !sum_valid_q || blk_en;
  assign in_ready_o = sum_en;

  always_comb begin
    a0          = in_i.aw[7:0];
    a1          = in_i.aw[15:8];
    sum_d.fmt   = in_i.fmt;
    sum_d.three = in_i.three;
    sum_d.c0    = in_i.c0;
    sum_d.c1    = in_i.c1;
    sum_d.idx   = in_i.idx;
    sum_d.aw    = in_i.aw;
    sum_d.geo   = in_i.geo;
    sum_d.awide = a0 > a1;
    for (int ch = 0; ch < 3; ch++) begin
      sum_d.mix2[ch] = 10'({in_i.c0[ch], 1'b0}) + 10'(in_i.c1[ch]);
      sum_d.mix3[ch] = 10'(in_i.c0[ch]) + 10'({in_i.c1[ch], 1'b0});
      sum_d.half[ch] = 8'((9'(in_i.c0[ch]) + 9'(in_i.c1[ch])) >> 1);
    end
    for (int i = 1; i <= 6; i++) begin
      sum_d.s7[i-1] = 11'(32'(7 - i) * 32'(a0) + 32'(i) * 32'(a1));
    end
    for (int i = 1; i <= 4; i++) begin
      sum_d.s5[i-1] = 11'(32'(5 - i) * 32'(a0) + 32'(i) * 32'(a1));
    end
  end

  always_comb begin
    blk_d.fmt = sum_q.fmt;
    blk_d.idx = sum_q.idx;
    blk_d.aw  = sum_q.aw;
    blk_d.geo = sum_q.geo;
    for (int ch = 0; ch < 3; ch++) begin
      blk_d.pal[0][ch] = sum_q.c0[ch];
      blk_d.pal[1][ch] = sum_q.c1[ch];
      if (sum_q.three) begin
        blk_d.pal[2][ch] = sum_q.half[ch];
        blk_d.pal[3][ch] = 8'h00;
      end else begin
        blk_d.pal[2][ch] = div3(sum_q.mix2[ch]);
        blk_d.pal[3][ch] = div3(sum_q.mix3[ch]);
      end
    end
    blk_d.pal[0][3] = 8'hFF;
    blk_d.pal[1][3] = 8'hFF;
    blk_d.pal[2][3] = 8'hFF;
    blk_d.pal[3][3] = sum_q.three ? 8'h00 : 8'hFF;
    blk_d.atab[0] = sum_q.aw[7:0];
    blk_d.atab[1] = sum_q.aw[15:8];
    if (sum_q.awide) begin
      for (int i = 1; i <= 6; i++) begin
        blk_d.atab[i+1] = div7(sum_q.s7[i-1]);
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        blk_d.atab[i+1] = div5(sum_q.s5[i-1]);
      end
      blk_d.atab[6] = 8'h00;
      blk_d.atab[7] = 8'hFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      blk_valid_q <= 1'b0;
    end else begin
      if (sum_en) begin
        sum_valid_q <= in_valid_i;
      end
      if (blk_en) begin
        blk_valid_q <= sum_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en && in_valid_i) begin
      sum_q <= sum_d;
    end
    if (blk_en && sum_valid_q) begin
      blk_q <= blk_d;
    end
  end

  assign out_valid_o = blk_valid_q;
  assign out_o       = blk_q;

endmodule

`default_nettype wire

[rtl/bcd_emit.sv]
`default_nettype none

module bcd_emit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire bcd_pkg::block_t  in_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output bcd_pkg::texel_t       out_o,
  output logic                  out_last_o
);
  import bcd_pkg::*;

  logic       busy_q, busy_d;
  logic [1:0] r_q, r_d, c_q, c_d;
  block_t     blk_q;
  logic       out_valid_q, out_valid_d;
  texel_t     texel_q, texel_d;
  logic       out_last_q;
  logic       adv, load, row_end, col_end, last, nonempty;
  logic [3:0] pix;
  logic [1:0] sel;
  logic [2:0] aidx;
  logic [3:0] nib;
  logic [5:0] abase;

  assign adv        = busy_q && (!out_valid_q || out_ready_i);
  assign col_end    = ({1'b0, c_q} + 3'd1) == blk_q.geo.ncol;
  assign row_end    = ({1'b0, r_q} + 3'd1) == blk_q.geo.nrow;
  assign last       = col_end && row_end;
  assign in_ready_o = !busy_q || (adv && last);
  assign load       = in_valid_i && in_ready_o;
  assign nonempty   = (in_i.geo.ncol != 3'd0) && (in_i.geo.nrow != 3'd0);

  always_comb begin
    busy_d = busy_q;
    r_d    = r_q;
    c_d    = c_q;
    if (load) begin
      busy_d = nonempty;
      r_d    = 2'd0;
      c_d    = 2'd0;
    end else if (adv) begin
      if (last) begin
        busy_d = 1'b0;
      end
      if (col_end) begin
        c_d = 2'd0;
        r_d = r_q + 2'd1;
      end else begin
        c_d = c_q + 2'd1;
      end
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    pix   = {r_q, c_q};
    sel   = blk_q.idx[{pix, 1'b0} +: 2];
    nib   = blk_q.aw[{pix, 2'b00} +: 4];
    abase = 6'd16 + 6'(pix) * 6'd3;
    aidx  = blk_q.aw[abase +: 3];
    texel_d.x     = {blk_q.geo.bx, c_q};
    texel_d.y     = {blk_q.geo.by, r_q};
    texel_d.red   = blk_q.pal[sel][0];
    texel_d.green = blk_q.pal[sel][1];
    texel_d.blue  = blk_q.pal[sel][2];
    unique case (blk_q.fmt)
      FMT_BC1: texel_d.alpha = blk_q.pal[sel][3];
      FMT_BC2: texel_d.alpha = {nib, nib};
      FMT_BC3: texel_d.alpha = blk_q.atab[aidx];
      FMT_RSV: texel_d.alpha = 8'hFF;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      r_q         <= 2'd0;
      c_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      r_q         <= r_d;
      c_q         <= c_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blk_q <= in_i;
    end
    if (adv) begin
      texel_q    <= texel_d;
      out_last_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = texel_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

[rtl/bcd_checker.sv]
`default_nettype none

module bcd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Output item withdrawn while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Output item changed while stalled.");

  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("Output item shown right after reset.");

  a_rst_ready: assert property (@(posedge clk_i)
    !rst_ni |=> s_axis_tready)
    else $error("Input not ready right after reset.");

endmodule

bind bc1_bc2_bc3_block_decoder bcd_checker u_bcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

[tb/bc1_bc2_bc3_block_decoder_tb.sv]
`default_nettype none

module bc1_bc2_bc3_block_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcd_pkg::*;

  localparam int unsigned LEVEL_CLAMP    = 16384;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PRINT_LIMIT    = 40;

  typedef struct {
    logic [63:0] cw;
    logic [63:0] aw;
    logic [14:0] w;
    logic [14:0] h;
    logic [11:0] bx;
    logic [11:0] by;
  } block_in_t;

  typedef struct {
    logic [13:0] x;
    logic [13:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        last;
  } texel_exp_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [1:0]      cfg_wdata;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;
  logic            m_axis_tlast;

  texel_exp_t  pending_texels[$];
  fmt_e        model_fmt;
  int unsigned mismatches;
  int unsigned blocks_sent;
  int unsigned texels_seen;
  int unsigned idle_cycles;
  int unsigned rx_hold_left;
  int unsigned rx_stall_left;
  bit          tx_idling;
  bit          rx_idling;

  bc1_bc2_bc3_block_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic void predict_texels(block_in_t blk);
    int unsigned w, h, px, py, sel, ai;
    int unsigned pal [4][4];
    int unsigned atab [8];
    int unsigned alpha [16];
    logic [15:0] e0, e1;
    logic        bc1;
    texel_exp_t  t;
    texel_exp_t  texels[$];
    w = (blk.w > LEVEL_CLAMP) ? LEVEL_CLAMP : blk.w;
    h = (blk.h > LEVEL_CLAMP) ? LEVEL_CLAMP : blk.h;
    e0 = blk.cw[15:0];
    e1 = blk.cw[31:16];
    bc1 = (model_fmt == FMT_BC1);
    pal[0][0] = widen5(e0[15:11]);
    pal[0][1] = widen6(e0[10:5]);
    pal[0][2] = widen5(e0[4:0]);
    pal[1][0] = widen5(e1[15:11]);
    pal[1][1] = widen6(e1[10:5]);
    pal[1][2] = widen5(e1[4:0]);
    pal[0][3] = 255;
    pal[1][3] = 255;
    pal[2][3] = 255;
    for (int c = 0; c < 3; c++) begin
      if (bc1 && e0 <= e1) begin
        pal[2][c] = (pal[0][c] + pal[1][c]) / 2;
        pal[3][c] = 0;
      end else begin
        pal[2][c] = (2 * pal[0][c] + pal[1][c]) / 3;
        pal[3][c] = (pal[0][c] + 2 * pal[1][c]) / 3;
      end
    end
    pal[3][3] = (bc1 && e0 <= e1) ? 0 : 255;

    for (int i = 0; i < 16; i++) alpha[i] = 255;
    if (model_fmt == FMT_BC2) begin
      for (int i = 0; i < 16; i++) alpha[i] = blk.aw[4*i +: 4] * 17;
    end else if (model_fmt == FMT_BC3) begin
      atab[0] = blk.aw[7:0];
      atab[1] = blk.aw[15:8];
      if (atab[0] > atab[1]) begin
        for (int i = 1; i <= 6; i++) atab[i+1] = ((7 - i) * atab[0] + i * atab[1]) / 7;
      end else begin
        for (int i = 1; i <= 4; i++) atab[i+1] = ((5 - i) * atab[0] + i * atab[1]) / 5;
        atab[6] = 0;
        atab[7] = 255;
      end
      for (int i = 0; i < 16; i++) begin
        ai = blk.aw[16 + 3*i +: 3];
        alpha[i] = atab[ai];
      end
    end

    for (int i = 0; i < 16; i++) begin
      px = blk.bx * 4 + (i % 4);
      py = blk.by * 4 + (i / 4);
      if (px < w && py < h) begin
        sel = blk.cw[32 + 2*i +: 2];
        t.x = px[13:0];
        t.y = py[13:0];
        t.r = pal[sel][0];
        t.g = pal[sel][1];
        t.b = pal[sel][2];
        t.a = bc1 ? pal[sel][3] : alpha[i];
        t.last = 1'b0;
        texels.push_back(t);
      end
    end
    if (texels.size() > 0) texels[texels.size()-1].last = 1'b1;
    foreach (texels[k]) pending_texels.push_back(texels[k]);
  endfunction

  function automatic block_in_t block_at(logic [63:0] cw, logic [63:0] aw, int unsigned w,
                                         int unsigned h, int unsigned bx, int unsigned by);
    block_in_t b;
    b.cw = cw;
    b.aw = aw;
    b.w = w[14:0];
    b.h = h[14:0];
    b.bx = bx[11:0];
    b.by = by[11:0];
    return b;
  endfunction

  function automatic block_in_t random_block();
    block_in_t   b;
    int unsigned mode;
    b.cw = {$urandom, $urandom};
    b.aw = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) b.cw[31:16] = b.cw[15:0];
    if ($urandom_range(0, 7) == 0) b.aw[15:8] = b.aw[7:0];
    mode = $urandom_range(0, 11);
    if (mode <= 7) begin
      b.w = 15'($urandom_range(1, 24));
      b.h = 15'($urandom_range(1, 24));
      b.bx = 12'($urandom_range(0, (b.w - 1) / 4));
      b.by = 12'($urandom_range(0, (b.h - 1) / 4));
    end else if (mode == 8) begin
      b.w = 15'($urandom);
      b.h = 15'($urandom);
      b.bx = 12'($urandom);
      b.by = 12'($urandom);
    end else if (mode == 9) begin
      b.w = 15'($urandom_range(16384, 32767));
      b.h = 15'($urandom_range(16384, 32767));
      b.bx = 12'($urandom);
      b.by = 12'($urandom);
    end else if (mode == 10) begin
      b.w = 15'($urandom_range(0, 20));
      b.h = 15'($urandom_range(1, 20));
      b.bx = 12'((b.w + 3) / 4 + $urandom_range(0, 2));
      b.by = 12'($urandom_range(0, (b.h - 1) / 4));
    end else begin
      b.w = 15'($urandom_range(1, 4095));
      b.h = 15'($urandom_range(1, 4095));
      b.bx = 12'((b.w - 1) / 4);
      b.by = 12'((b.h - 1) / 4);
    end
    return b;
  endfunction

  task automatic send_block(block_in_t b);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, b.by, b.bx, b.h, b.w, b.aw, b.cw};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_texels(b);
    blocks_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(fmt_e f);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_fmt = f;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("Mismatch at texel %0d: %s is %0d, expected %0d", texels_seen, what, got, want);
  endtask

  // Checks every delivered texel against the oldest pending prediction.
  always @(posedge clk) begin
    texel_t     got;
    texel_exp_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got = texel_t'(m_axis_tdata[$bits(texel_t)-1:0]);
      if (pending_texels.size() == 0) begin
        report_mismatch("texel with nothing pending, x", got.x, 0);
      end else begin
        want = pending_texels.pop_front();
        if (got.x !== want.x) report_mismatch("texel_x", got.x, want.x);
        if (got.y !== want.y) report_mismatch("texel_y", got.y, want.y);
        if (got.red !== want.r) report_mismatch("red", got.red, want.r);
        if (got.green !== want.g) report_mismatch("green", got.green, want.g);
        if (got.blue !== want.b) report_mismatch("blue", got.blue, want.b);
        if (got.alpha !== want.a) report_mismatch("alpha", got.alpha, want.a);
        if (m_axis_tlast !== want.last) report_mismatch("last_texel", m_axis_tlast, want.last);
      end
      texels_seen++;
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall_left--;
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        rx_stall_left = $urandom_range(0, 12);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("No item moved for %0d cycles, %0d texels still pending.",
               idle_cycles, pending_texels.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_bc1_color_modes();
    set_format(FMT_BC1);
    send_block(block_at(64'hE4E4E4E4_0000FFFF, 64'h0, 4, 4, 0, 0));
    send_block(block_at(64'hE4E4E4E4_FFFF0000, 64'h0, 4, 4, 0, 0));
    send_block(block_at(64'h1B1B1B1B_7BEF7BEF, {$urandom, $urandom}, 4, 4, 0, 0));
    send_block(block_at(64'hFFFFFFFF_A8145A2B, 64'h0, 8, 8, 1, 1));
    wait_drained();
  endtask

  task automatic test_bc2_explicit_alpha();
    set_format(FMT_BC2);
    send_block(block_at(64'hE4E4E4E4_07E0F800, 64'hFEDCBA98_76543210, 4, 4, 0, 0));
    send_block(block_at(64'h4E4E4E4E_F800001F, 64'hFFFFFFFF_FFFFFFFF, 4, 4, 0, 0));
    send_block(block_at(64'hE4E4E4E4_FFFF0000, 64'h0, 4, 4, 0, 0));
    wait_drained();
  endtask

  task automatic test_bc3_alpha_table();
    logic [63:0] aw;
    aw = '0;
    for (int p = 0; p < 16; p++) aw[16 + 3*p +: 3] = 3'(p);
    set_format(FMT_BC3);
    aw[15:0] = 16'h00FF;
    send_block(block_at(64'hE4E4E4E4_F81F07FF, aw, 4, 4, 0, 0));
    aw[15:0] = 16'hFF00;
    send_block(block_at(64'hE4E4E4E4_07FFF81F, aw, 4, 4, 0, 0));
    aw[15:0] = 16'h8080;
    send_block(block_at(64'hE4E4E4E4_12341234, aw, 4, 4, 0, 0));
    aw[15:0] = 16'h3D9A;
    send_block(block_at(64'h9C9C9C9C_0000FFFF, aw, 4, 4, 0, 0));
    wait_drained();
  endtask

  task automatic test_reserved_format();
    set_format(FMT_RSV);
    send_block(block_at(64'hE4E4E4E4_FFFF0000, {$urandom, $urandom}, 4, 4, 0, 0));
    send_block(block_at(64'hE4E4E4E4_0000FFFF, {$urandom, $urandom}, 4, 4, 0, 0));
    wait_drained();
  endtask

  task automatic test_level_bounds();
    set_format(FMT_BC3);
    send_block(block_at({$urandom, $urandom}, {$urandom, $urandom}, 0, 4, 0, 0));
    send_block(block_at({$urandom, $urandom}, {$urandom, $urandom}, 4, 0, 0, 0));
    send_block(block_at({$urandom, $urandom}, {$urandom, $urandom}, 5, 6, 1, 1));
    send_block(block_at({$urandom, $urandom}, {$urandom, $urandom}, 5, 5, 2, 0));
    send_block(block_at({$urandom, $urandom}, {$urandom, $urandom}, 32767, 32767, 4095, 4095));
    send_block(block_at({$urandom, $urandom}, {$urandom, $urandom}, 16385, 16384, 4095, 0));
    send_block(block_at({$urandom, $urandom}, {$urandom, $urandom}, 16383, 16383, 4095, 4095));
    send_block(block_at({$urandom, $urandom}, {$urandom, $urandom}, 1, 1, 0, 0));
    send_block(block_at({$urandom, $urandom}, {$urandom, $urandom}, 7, 2, 1, 0));
    wait_drained();
  endtask

  task automatic test_random_blocks();
    fmt_e order [4];
    order = '{FMT_BC2, FMT_RSV, FMT_BC1, FMT_BC3};
    foreach (order[f]) begin
      set_format(order[f]);
      for (int i = 0; i < 72; i++) begin
        if (i % 18 == 0) begin
          tx_idling = ($urandom_range(0, 3) != 0);
          rx_idling = ($urandom_range(0, 3) != 0);
        end
        send_block(random_block());
      end
      wait_drained();
    end
  endtask

  task automatic test_output_holdoff();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    rx_hold_left = 300;
    for (int i = 0; i < 24; i++)
      send_block(block_at({$urandom, $urandom}, {$urandom, $urandom}, 64, 64,
                          $urandom_range(0, 15), $urandom_range(0, 15)));
    wait_drained();
  endtask

  task automatic test_steady_stream();
    set_format(FMT_BC1);
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    for (int i = 0; i < 30; i++) send_block(random_block());
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= FMT_BC1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    model_fmt = FMT_BC1;
    mismatches = 0;
    blocks_sent = 0;
    texels_seen = 0;
    rx_hold_left = 0;
    rx_stall_left = 0;
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bc1_color_modes();
    test_bc2_explicit_alpha();
    test_bc3_alpha_table();
    test_reserved_format();
    test_level_bounds();
    test_random_blocks();
    test_output_holdoff();
    test_steady_stream();

    if (pending_texels.size() != 0) report_mismatch("texels never delivered", 0,
                                                    pending_texels.size());
    $display("Decoded %0d blocks in all four format codes, with partial, empty and clamped levels.",
             blocks_sent);
    $display("Compared %0d texels under idle bursts and a long output hold-off; %0d mismatches.",
             texels_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
